FILE: src/clt_pkg.sv
// shared types, constants and charset table for the character lcd text writer
package clt_pkg;

    localparam logic [1:0] LINE_MODE_ONE  = 2'd0;
    localparam logic [1:0] LINE_MODE_TWO  = 2'd1;
    localparam logic [1:0] LINE_MODE_FOUR = 2'd2;

    localparam logic       CFG_LINE_MODE  = 1'b0;
    localparam logic       CFG_LINE_WIDTH = 1'b1;

    localparam logic       KIND_TEXT  = 1'b0;
    localparam logic       KIND_INSTR = 1'b1;

    localparam logic       RS_INSTR = 1'b0;
    localparam logic       RS_DATA  = 1'b1;

    localparam logic [6:0] LINE1_START = 7'h00;
    localparam logic [6:0] LINE2_START = 7'h40;
    localparam logic [6:0] LINE3_START = 7'h14;
    localparam logic [6:0] LINE4_START = 7'h54;
    localparam logic       SET_ADDR    = 1'b1;
    localparam logic [7:0] LINE_FEED   = 8'h0A;

    localparam logic [1:0] LINE_MODE_RESET  = LINE_MODE_TWO;
    localparam logic [5:0] LINE_WIDTH_RESET = 6'd16;

    // one decoded item: optional instruction byte, then the main byte
    typedef struct packed {
        logic       has_cmd;
        logic [7:0] cmd_byte;
        logic       data_rs;
        logic [7:0] data_byte;
    } clt_entry_t;

    function automatic logic [7:0] cyr_map(input logic [5:0] idx);
        logic [7:0] r;
        unique case (idx)
            6'd0:  r = 8'h41; 6'd1:  r = 8'ha0; 6'd2:  r = 8'h42; 6'd3:  r = 8'ha1;
            6'd4:  r = 8'he0; 6'd5:  r = 8'h45; 6'd6:  r = 8'ha3; 6'd7:  r = 8'ha4;
            6'd8:  r = 8'ha5; 6'd9:  r = 8'ha6; 6'd10: r = 8'h4b; 6'd11: r = 8'ha7;
            6'd12: r = 8'h4d; 6'd13: r = 8'h48; 6'd14: r = 8'h4f; 6'd15: r = 8'ha8;
            6'd16: r = 8'h50; 6'd17: r = 8'h43; 6'd18: r = 8'h54; 6'd19: r = 8'ha9;
            6'd20: r = 8'haa; 6'd21: r = 8'h58; 6'd22: r = 8'he1; 6'd23: r = 8'hab;
            6'd24: r = 8'hac; 6'd25: r = 8'he2; 6'd26: r = 8'had; 6'd27: r = 8'hae;
            6'd28: r = 8'h62; 6'd29: r = 8'haf; 6'd30: r = 8'hb0; 6'd31: r = 8'hb1;
            6'd32: r = 8'h61; 6'd33: r = 8'hb2; 6'd34: r = 8'hb3; 6'd35: r = 8'hb4;
            6'd36: r = 8'he3; 6'd37: r = 8'h65; 6'd38: r = 8'hb6; 6'd39: r = 8'hb7;
            6'd40: r = 8'hb8; 6'd41: r = 8'hb9; 6'd42: r = 8'hba; 6'd43: r = 8'hbb;
            6'd44: r = 8'hbc; 6'd45: r = 8'hbd; 6'd46: r = 8'h6f; 6'd47: r = 8'hbe;
            6'd48: r = 8'h70; 6'd49: r = 8'h63; 6'd50: r = 8'hbf; 6'd51: r = 8'h79;
            6'd52: r = 8'he4; 6'd53: r = 8'h78; 6'd54: r = 8'he5; 6'd55: r = 8'hc0;
            6'd56: r = 8'hc1; 6'd57: r = 8'he6; 6'd58: r = 8'hc2; 6'd59: r = 8'hc3;
            6'd60: r = 8'hc4; 6'd61: r = 8'hc5; 6'd62: r = 8'hc6; 6'd63: r = 8'hc7;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] map_char(input logic [7:0] c);
        logic [7:0] r;
        priority if (c == 8'hA8) r = 8'hA2;
        else if (c == 8'hB8)     r = 8'hB5;
        else if (c == 8'h08)     r = 8'hFF;
        else if (c[7:6] == 2'b11) r = cyr_map(c[5:0]);
        else                     r = c;
        return r;
    endfunction

endpackage

FILE: src/char_lcd_text_writer.sv
// top level of the character lcd text writer
// Each accepted item becomes nibble transfers for a 4-bit character display,
// high nibble first: a raw instruction or line feed gives two nibbles, a text
// character two, or four when a line-wrap address command goes first. The
// back end sends one nibble per cycle through its output register while
// m_tready does not stall it. Items are accepted whenever the queue has
// room; the first nibble of an item passes through the queue and then the
// output register. Write line_mode and line_width only while no item is
// in flight.
module char_lcd_text_writer
    import clt_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [5:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // byte_value [7:0], address_counter [14:8], zero [15]
    input  logic        s_tuser,   // kind [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // nibble [3:0], zero [7:4]
    output logic        m_tuser,   // reg_select [0]
    output logic        m_tlast
);

    logic       q_full;
    logic       q_not_empty;
    logic       q_push;
    logic       q_pop;
    clt_entry_t q_entry;
    clt_entry_t q_head;

    clt_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_tvalid),
        .in_kind   (s_tuser),
        .in_byte   (s_tdata[7:0]),
        .in_addr   (s_tdata[14:8]),
        .q_full    (q_full),
        .in_ready  (s_tready),
        .q_push    (q_push),
        .q_entry   (q_entry)
    );

    clt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .full       (q_full),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    clt_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

FILE: src/clt_front.sv
// front end: configuration registers and item classification into queue entries
module clt_front
    import clt_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_addr,
    input  logic [5:0] cfg_wdata,
    input  logic       in_valid,
    input  logic       in_kind,
    input  logic [7:0] in_byte,
    input  logic [6:0] in_addr,
    input  logic       q_full,
    output logic       in_ready,
    output logic       q_push,
    output clt_entry_t q_entry
);

    logic [1:0] line_mode_reg;
    logic [5:0] line_width_reg;
    logic [6:0] width_ext;
    logic [6:0] next_start;
    logic       wrap_l1;
    logic       wrap_l2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_mode_reg  <= LINE_MODE_RESET;
            line_width_reg <= LINE_WIDTH_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_LINE_MODE:  line_mode_reg  <= cfg_wdata[1:0];
                CFG_LINE_WIDTH: line_width_reg <= cfg_wdata;
                default:        line_mode_reg  <= line_mode_reg;
            endcase
        end
    end

    assign in_ready  = !q_full;
    assign q_push    = in_valid && !q_full;
    assign width_ext = {1'b0, line_width_reg};
    assign wrap_l1   = (in_addr == LINE1_START + width_ext);
    assign wrap_l2   = (in_addr == LINE2_START + width_ext);

    always_comb begin
        unique case (line_mode_reg)
            LINE_MODE_ONE: next_start = LINE1_START;
            LINE_MODE_TWO: next_start = (in_addr < LINE2_START) ? LINE2_START : LINE1_START;
            default: begin
                priority if (in_addr < LINE3_START)
                    next_start = LINE2_START;
                else if (in_addr >= LINE2_START && in_addr < LINE4_START)
                    next_start = LINE3_START;
                else if (in_addr >= LINE3_START && in_addr < LINE2_START)
                    next_start = LINE4_START;
                else
                    next_start = LINE1_START;
            end
        endcase
    end

    always_comb begin
        q_entry.has_cmd   = 1'b0;
        q_entry.cmd_byte  = {SET_ADDR, LINE1_START};
        q_entry.data_rs   = RS_INSTR;
        q_entry.data_byte = in_byte;
        if (in_kind == KIND_INSTR) begin
            q_entry.data_byte = in_byte;
        end else if (in_byte == LINE_FEED) begin
            q_entry.data_byte = {SET_ADDR, next_start};
        end else begin
            q_entry.data_rs   = RS_DATA;
            q_entry.data_byte = map_char(in_byte);
            unique case (line_mode_reg)
                LINE_MODE_ONE: begin
                    q_entry.has_cmd  = wrap_l1;
                    q_entry.cmd_byte = {SET_ADDR, LINE1_START};
                end
                LINE_MODE_TWO: begin
                    q_entry.has_cmd  = wrap_l1 || wrap_l2;
                    q_entry.cmd_byte = wrap_l1 ? {SET_ADDR, LINE2_START}
                                               : {SET_ADDR, LINE1_START};
                end
                default: q_entry.has_cmd = 1'b0;
            endcase
        end
    end

endmodule

FILE: src/clt_queue.sv
// small first-word-fall-through queue between front and back end
module clt_queue
    import clt_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  clt_entry_t push_entry,
    input  logic       pop,
    output logic       full,
    output logic       not_empty,
    output clt_entry_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    clt_entry_t       mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_next;
    logic             do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_pop    = pop && not_empty;
    assign head      = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: src/clt_back.sv
// back end: splits queue entries into nibble transfers behind an output register
module clt_back
    import clt_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_not_empty,
    input  clt_entry_t q_head,
    output logic       q_pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tuser,
    output logic       m_tlast
);

    logic [1:0] step_reg;
    logic [1:0] step_next;
    logic       valid_reg;
    logic [3:0] nibble_reg;
    logic       rs_reg;
    logic       last_reg;
    logic [1:0] idx;
    logic       load;
    logic       is_last;
    logic [3:0] nib;
    logic       rs;

    assign load    = q_not_empty && (!valid_reg || m_tready);
    assign idx     = q_head.has_cmd ? step_reg : step_reg + 2'd2;
    assign is_last = (idx == 2'd3);
    assign q_pop   = load && is_last;

    always_comb begin
        unique case (idx)
            2'd0:    nib = q_head.cmd_byte[7:4];
            2'd1:    nib = q_head.cmd_byte[3:0];
            2'd2:    nib = q_head.data_byte[7:4];
            default: nib = q_head.data_byte[3:0];
        endcase
        rs = idx[1] ? q_head.data_rs : RS_INSTR;
    end

    always_comb begin
        step_next = step_reg;
        if (load) begin
            step_next = is_last ? 2'd0 : step_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            step_reg <= step_next;
            if (load) begin
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            nibble_reg <= nib;
            rs_reg     <= rs;
            last_reg   <= is_last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'h0, nibble_reg};
    assign m_tuser  = rs_reg;
    assign m_tlast  = last_reg;

endmodule

FILE: src/clt_checker.sv
// port-level assertions for the character lcd text writer, bound to the top level
module clt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:4] == 4'h0))
        else $error("nibble padding bits not zero");

    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result valid dropped while stalled");

    a_data_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("result item changed while stalled");

endmodule

bind char_lcd_text_writer clt_checker u_clt_checker (.*);
